[design/s9wd_pkg.sv]
package s9wd_pkg;

	// Width of the remaining-values counter.
	localparam int COUNT_BITS = 24;

	localparam int LIST_LEN_BITS = 24;
	localparam int MODE_BITS     = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int SLOT_BITS     = 28;
	localparam int SLOT_IDX_BITS = 5;

	localparam logic [CFG_IDX_BITS-1:0] REG_LIST_LENGTH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DECODE_MODE = 2'd1;

	localparam logic [MODE_BITS-1:0] MODE_PLAIN = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_GAP   = 2'd1;

	localparam logic [3:0] SEL_MAX = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SKIP,
		ST_SCAN,
		ST_REWIND,
		ST_EMIT,
		ST_ERR
	} step_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_TAKE,
		OP_SCAN,
		OP_REWIND,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ACCEPT,
		C_BAD_SEL,
		C_NO_TAKE,
		C_SCAN_ERR,
		C_MORE_SLOTS,
		C_NO_EMIT,
		C_EMIT_END,
		C_OUT_STALL
	} cond_t;

	typedef struct packed {
		op_t   op;
		logic  err_out;
		cond_t jump_cond;
		step_t jump_to;
		cond_t hold_cond;
		step_t next_step;
	} ctrl_t;

	// Microprogram. Priority inside a step: jump, then hold, then next step.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '{OP_NONE, 1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE};
		unique case (s)
			ST_IDLE:   c = '{OP_LOAD,   1'b0, C_NEVER,    ST_IDLE, C_NO_ACCEPT,  ST_CHECK};
			ST_CHECK:  c = '{OP_TAKE,   1'b0, C_BAD_SEL,  ST_ERR,  C_NEVER,      ST_SKIP};
			ST_SKIP:   c = '{OP_NONE,   1'b0, C_NO_TAKE,  ST_IDLE, C_NEVER,      ST_SCAN};
			ST_SCAN:   c = '{OP_SCAN,   1'b0, C_SCAN_ERR, ST_ERR,  C_MORE_SLOTS, ST_REWIND};
			ST_REWIND: c = '{OP_REWIND, 1'b0, C_NO_EMIT,  ST_IDLE, C_NEVER,      ST_EMIT};
			ST_EMIT:   c = '{OP_EMIT,   1'b0, C_EMIT_END, ST_IDLE, C_ALWAYS,     ST_IDLE};
			ST_ERR:    c = '{OP_NONE,   1'b1, C_NEVER,    ST_IDLE, C_OUT_STALL,  ST_IDLE};
			default:   c = '{OP_NONE,   1'b0, C_NEVER,    ST_IDLE, C_NEVER,      ST_IDLE};
		endcase
		return c;
	endfunction

	function automatic logic [SLOT_IDX_BITS-1:0] slot_count(input logic [3:0] sel);
		logic [SLOT_IDX_BITS-1:0] n;
		unique case (sel)
			4'd0:    n = 5'd1;
			4'd1:    n = 5'd2;
			4'd2:    n = 5'd3;
			4'd3:    n = 5'd4;
			4'd4:    n = 5'd5;
			4'd5:    n = 5'd7;
			4'd6:    n = 5'd9;
			4'd7:    n = 5'd14;
			4'd8:    n = 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic [SLOT_IDX_BITS-1:0] slot_width(input logic [3:0] sel);
		logic [SLOT_IDX_BITS-1:0] w;
		unique case (sel)
			4'd0:    w = 5'd28;
			4'd1:    w = 5'd14;
			4'd2:    w = 5'd9;
			4'd3:    w = 5'd7;
			4'd4:    w = 5'd5;
			4'd5:    w = 5'd4;
			4'd6:    w = 5'd3;
			4'd7:    w = 5'd2;
			4'd8:    w = 5'd1;
			default: w = 5'd0;
		endcase
		return w;
	endfunction

endpackage

[design/simple9_word_decoder.sv]
// Simple-9 word decoder.
// Input channel: one packed 32-bit word per beat (in_valid / in_stall) with
// start_list, which reloads the remaining count from list_length and clears the
// running sum before the word is decoded. Output channel: one decoded value per
// beat (out_valid / out_stall) with last_of_word, list_done and format_error.
// Configuration: list_length (index 0) and decode_mode (index 1) through
// cfg_we / cfg_index / cfg_data, written while the block is idle.
// Control is a small microprogram. Each word runs a scan pass over the slots it
// consumes, one slot per cycle, that finds a zero after a boundary and the last
// slot that yields a result, then an emit pass, one slot per cycle while
// out_stall is low. A bad selector or a zero after a boundary gives a lone
// error beat, and a word that consumes nothing gives no beat. in_stall is low
// only while the sequencer waits for a word. While out_stall is high the emit
// pass holds on a slot that offers a beat, with the beat unchanged. Reset
// clears both configuration registers, the remaining count and the running
// sum, and leaves the sequencer waiting for a word.
module simple9_word_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] packed_word,
	input  logic        start_list,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] decoded_value,
	output logic        last_of_word,
	output logic        list_done,
	output logic        format_error,
	input  logic        cfg_we,
	input  logic [s9wd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [s9wd_pkg::LIST_LEN_BITS-1:0] cfg_data
);

	localparam int CB = s9wd_pkg::COUNT_BITS;
	localparam int SB = s9wd_pkg::SLOT_BITS;
	localparam int IB = s9wd_pkg::SLOT_IDX_BITS;

	s9wd_pkg::step_t step_q, step_d;
	s9wd_pkg::ctrl_t ctrl;

	logic [s9wd_pkg::LIST_LEN_BITS-1:0] list_length_q;
	logic [s9wd_pkg::MODE_BITS-1:0]     decode_mode_q;
	logic [CB-1:0] values_left_q, left_w_q;
	logic [31:0]   running_sum_q, sum_w_q;
	logic [31:0]   word_q;
	logic [SB-1:0] bits_q;
	logic [IB-1:0] take_q, cnt_q, last_idx_q;
	logic          any_q;

	logic [3:0]    sel;
	logic [IB-1:0] width;
	logic [SB-1:0] mask;
	logic [31:0]   v, ns, val;
	logic          s_emit, s_err;
	logic          accept, advance, cond_jump, cond_hold;
	logic [CB-1:0] reload;

	assign sel    = word_q[31:28];
	assign width  = s9wd_pkg::slot_width(sel);
	assign mask   = (SB'(1) << width) - SB'(1);
	assign v      = {{(32-SB){1'b0}}, bits_q & mask};
	assign ctrl   = s9wd_pkg::ucode(step_q);
	assign reload = CB'(list_length_q);
	assign accept = in_valid && !in_stall;

	// One slot against the working sum; shared by the scan and emit passes.
	always_comb begin
		ns     = sum_w_q;
		val    = v;
		s_emit = 1'b1;
		s_err  = 1'b0;
		if (decode_mode_q == s9wd_pkg::MODE_PLAIN) begin
			val = v;
		end else if (decode_mode_q == s9wd_pkg::MODE_GAP) begin
			ns  = sum_w_q + v;
			val = ns;
		end else if (sum_w_q == 32'd0) begin
			s_err = (v == 32'd0);
			ns    = v;
			val   = v - 32'd1;
		end else if (v != 32'd0) begin
			ns  = sum_w_q + v - 32'd1;
			val = ns - 32'd1;
		end else begin
			ns     = 32'd0;
			s_emit = 1'b0;
		end
	end

	assign advance = !s_emit || !out_stall;

	always_comb begin
		cond_jump = 1'b0;
		cond_hold = 1'b0;
		unique case (ctrl.jump_cond)
			s9wd_pkg::C_BAD_SEL:  cond_jump = (sel > s9wd_pkg::SEL_MAX);
			s9wd_pkg::C_NO_TAKE:  cond_jump = (take_q == '0);
			s9wd_pkg::C_SCAN_ERR: cond_jump = s_err;
			s9wd_pkg::C_NO_EMIT:  cond_jump = !any_q;
			s9wd_pkg::C_EMIT_END: cond_jump = advance && (cnt_q == last_idx_q);
			s9wd_pkg::C_ALWAYS:   cond_jump = 1'b1;
			default:              cond_jump = 1'b0;
		endcase
		unique case (ctrl.hold_cond)
			s9wd_pkg::C_NO_ACCEPT:  cond_hold = !accept;
			s9wd_pkg::C_MORE_SLOTS: cond_hold = (cnt_q != take_q - IB'(1));
			s9wd_pkg::C_OUT_STALL:  cond_hold = out_stall;
			s9wd_pkg::C_ALWAYS:     cond_hold = 1'b1;
			default:                cond_hold = 1'b0;
		endcase
		if (cond_jump) begin
			step_d = ctrl.jump_to;
		end else if (cond_hold) begin
			step_d = step_q;
		end else begin
			step_d = ctrl.next_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= s9wd_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_length_q <= '0;
			decode_mode_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == s9wd_pkg::REG_LIST_LENGTH) begin
				list_length_q <= cfg_data;
			end else if (cfg_index == s9wd_pkg::REG_DECODE_MODE) begin
				decode_mode_q <= cfg_data[s9wd_pkg::MODE_BITS-1:0];
			end
		end
	end

	// Architectural list state; a word commits by swapping with the working copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			values_left_q <= '0;
			running_sum_q <= '0;
		end else if (ctrl.op == s9wd_pkg::OP_LOAD && accept && start_list) begin
			values_left_q <= reload;
			running_sum_q <= '0;
		end else if (ctrl.op == s9wd_pkg::OP_REWIND) begin
			values_left_q <= left_w_q;
			running_sum_q <= sum_w_q;
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			s9wd_pkg::OP_LOAD: begin
				if (accept) begin
					word_q   <= packed_word;
					bits_q   <= packed_word[SB-1:0];
					left_w_q <= start_list ? reload : values_left_q;
					sum_w_q  <= start_list ? 32'd0 : running_sum_q;
				end
			end
			s9wd_pkg::OP_TAKE: begin
				if (left_w_q < CB'(s9wd_pkg::slot_count(sel))) begin
					take_q <= left_w_q[IB-1:0];
				end else begin
					take_q <= s9wd_pkg::slot_count(sel);
				end
				cnt_q      <= '0;
				any_q      <= 1'b0;
				last_idx_q <= '0;
			end
			s9wd_pkg::OP_SCAN: begin
				sum_w_q  <= ns;
				left_w_q <= left_w_q - CB'(1);
				bits_q   <= bits_q >> width;
				cnt_q    <= cnt_q + IB'(1);
				if (s_emit) begin
					last_idx_q <= cnt_q;
					any_q      <= 1'b1;
				end
			end
			s9wd_pkg::OP_REWIND: begin
				left_w_q <= values_left_q;
				sum_w_q  <= running_sum_q;
				bits_q   <= word_q[SB-1:0];
				cnt_q    <= '0;
			end
			s9wd_pkg::OP_EMIT: begin
				if (advance) begin
					sum_w_q  <= ns;
					left_w_q <= left_w_q - CB'(1);
					bits_q   <= bits_q >> width;
					cnt_q    <= cnt_q + IB'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (step_q != s9wd_pkg::ST_IDLE);

	always_comb begin
		if (ctrl.err_out) begin
			out_valid     = 1'b1;
			decoded_value = 32'd0;
			last_of_word  = 1'b1;
			list_done     = (values_left_q == '0);
			format_error  = 1'b1;
		end else begin
			out_valid     = (ctrl.op == s9wd_pkg::OP_EMIT) && s_emit;
			decoded_value = val;
			last_of_word  = (cnt_q == last_idx_q);
			list_done     = (left_w_q == CB'(1));
			format_error  = 1'b0;
		end
	end

	a_no_beat_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("result beat offered while waiting for a word");

	a_error_beat_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_error |-> last_of_word && (decoded_value == 32'd0))
		else $error("error beat is not a lone zero result");

	a_error_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_error && !out_stall |=> !in_stall)
		else $error("sequencer did not return to idle after an error beat");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == s9wd_pkg::ST_SCAN || step_q == s9wd_pkg::ST_EMIT) |->
			(cnt_q < take_q))
		else $error("slot index ran past the slots taken from the word");

endmodule

[dv/simple9_word_decoder_tb.sv]
module simple9_word_decoder_tb;

	localparam logic [1:0] MODE_BOUNDARY     = 2'd2;
	localparam logic [1:0] MODE_BOUNDARY_ALT = 2'd3;

	localparam logic [3:0] SEL_1X28 = 4'd0;
	localparam logic [3:0] SEL_5X5  = 4'd4;
	localparam logic [3:0] SEL_14X2 = 4'd7;
	localparam logic [3:0] SEL_28X1 = 4'd8;
	localparam logic [3:0] SEL_TOP  = 4'd15;

	localparam int QUIET_CYCLES = 70;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD    = 300;
	localparam int RAND_PHASES  = 9;
	localparam int PHASE_ITEMS  = 24;
	localparam int WRAP_PHASE   = 2;
	localparam int HOLD_PHASE   = 4;
	localparam int PAUSE_PHASE  = 5;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
		logic        done;
		logic        err;
	} dec_beat_t;

	class decode_scoreboard;
		logic [23:0] list_length;
		logic [1:0]  decode_mode;
		logic [23:0] values_left;
		logic [31:0] running_sum;
		bit          took_any;
		int          errors;
		dec_beat_t   owed_beats[$];

		function new();
			list_length = '0;
			decode_mode = '0;
			values_left = '0;
			running_sum = '0;
			took_any = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [23:0] data);
			if (idx == s9wd_pkg::REG_LIST_LENGTH) begin
				list_length = data;
			end else if (idx == s9wd_pkg::REG_DECODE_MODE) begin
				decode_mode = data[1:0];
			end
		endfunction

		function void packing(input logic [3:0] sel, output int n, output int w);
			case (sel)
				4'd0: begin n = 1; w = 28; end
				4'd1: begin n = 2; w = 14; end
				4'd2: begin n = 3; w = 9; end
				4'd3: begin n = 4; w = 7; end
				4'd4: begin n = 5; w = 5; end
				4'd5: begin n = 7; w = 4; end
				4'd6: begin n = 9; w = 3; end
				4'd7: begin n = 14; w = 2; end
				4'd8: begin n = 28; w = 1; end
				default: begin n = 0; w = 0; end
			endcase
		endfunction

		function dec_beat_t error_beat();
			return '{32'd0, 1'b1, values_left == 24'd0, 1'b1};
		endfunction

		// Expected beats of one accepted word, appended in order.
		function void decode_word(logic [31:0] word, logic start);
			logic [3:0]  sel;
			logic [23:0] left;
			logic [31:0] sum, bits, mask, v, val;
			int          n, w, take, i;
			bit          emit, bad;
			dec_beat_t   fresh[$];
			if (start) begin
				values_left = list_length;
				running_sum = '0;
			end
			sel = word[31:28];
			took_any = 1'b1;
			if (sel > s9wd_pkg::SEL_MAX) begin
				owed_beats.push_back(error_beat());
				return;
			end
			packing(sel, n, w);
			take = (n > values_left) ? int'(values_left) : n;
			took_any = (take > 0);
			left = values_left;
			sum = running_sum;
			bits = {4'h0, word[27:0]};
			mask = (32'd1 << w) - 32'd1;
			bad = 1'b0;
			for (i = 0; i < take; i++) begin
				v = bits & mask;
				bits = bits >> w;
				left = left - 24'd1;
				emit = 1'b1;
				val = v;
				if (decode_mode == s9wd_pkg::MODE_PLAIN) begin
					val = v;
				end else if (decode_mode == s9wd_pkg::MODE_GAP) begin
					sum = sum + v;
					val = sum;
				end else if (sum == 32'd0) begin
					// A zero while sitting on a boundary spoils the whole word.
					if (v == 32'd0) begin
						bad = 1'b1;
						break;
					end
					val = v - 32'd1;
					sum = v;
				end else if (v != 32'd0) begin
					sum = sum + v - 32'd1;
					val = sum - 32'd1;
				end else begin
					sum = '0;
					emit = 1'b0;
				end
				if (emit) begin
					fresh.push_back('{val, 1'b0, left == 24'd0, 1'b0});
				end
			end
			if (bad) begin
				owed_beats.push_back(error_beat());
				return;
			end
			if (fresh.size() > 0) begin
				fresh[fresh.size()-1].last = 1'b1;
			end
			foreach (fresh[k]) begin
				owed_beats.push_back(fresh[k]);
			end
			values_left = left;
			running_sum = sum;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(dec_beat_t got);
			dec_beat_t want;
			if (owed_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual value %0h last %b done %b err %b",
					$time, got.value, got.last, got.done, got.err);
				errors++;
				return;
			end
			want = owed_beats.pop_front();
			compare_field("decoded_value", want.value, got.value);
			compare_field("last_of_word", 32'(want.last), 32'(got.last));
			compare_field("list_done", 32'(want.done), 32'(got.done));
			compare_field("format_error", 32'(want.err), 32'(got.err));
		endfunction

		function int pending();
			return owed_beats.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] packed_word = '0;
	logic        start_list = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] decoded_value;
	logic        last_of_word;
	logic        list_done;
	logic        format_error;
	logic        cfg_we = 1'b0;
	logic [s9wd_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [s9wd_pkg::LIST_LEN_BITS-1:0] cfg_data = '0;

	decode_scoreboard sb = new();
	int items_taken = 0;
	bit sender_calm = 1'b0;
	bit hold_req = 1'b0;

	simple9_word_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.packed_word(packed_word),
		.start_list(start_list),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.decoded_value(decoded_value),
		.last_of_word(last_of_word),
		.list_done(list_done),
		.format_error(format_error),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.decode_word(packed_word, start_list);
			end
			if (out_valid && !out_stall) begin
				sb.check_beat('{decoded_value, last_of_word, list_done, format_error});
			end
		end
	end

	// Receiver: a random hold-off before each beat, calm stretches, and one long stall.
	initial begin : receiver
		int  hold;
		int  beats;
		bit  calm;
		beats = 0;
		calm = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 7);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(negedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
			beats++;
			if (beats % 40 == 0) begin
				calm = ($urandom_range(0, 2) == 0);
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic offer(input logic [31:0] w, input logic st);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		packed_word <= w;
		start_list <= st;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (sb.took_any) begin
			items_taken++;
		end
	endtask

	// Drop valid, wait for all owed beats, then give words without results time to finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// Random slot contents; in boundary mode a tidy word never puts a zero on a boundary.
	function automatic logic [31:0] build_word(input logic [3:0] sel, input logic st, input bit tidy);
		logic [31:0] w;
		logic [27:0] slot_v, mask;
		bit          bnd;
		int          n, sw, k;
		if (sel > s9wd_pkg::SEL_MAX) begin
			return {sel, 28'($urandom)};
		end
		sb.packing(sel, n, sw);
		mask = (28'd1 << sw) - 28'd1;
		bnd = st || (sb.running_sum == 32'd0);
		w = {sel, 28'h0};
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: slot_v = '0;
				1: slot_v = mask;
				2: slot_v = 28'd1;
				default: slot_v = 28'($urandom) & mask;
			endcase
			if (tidy && sb.decode_mode[1]) begin
				if (bnd && slot_v == '0) begin
					slot_v = 28'd1;
				end
				bnd = (slot_v == '0);
			end
			w[27:0] = w[27:0] | (slot_v << (k * sw));
		end
		return w;
	endfunction

	// Large gaps until the running sum lands exactly on zero, then a zero slot.
	task automatic wrap_run();
		logic [31:0] need;
		offer({SEL_1X28, 28'hFFFFFFF}, 1'b1);
		repeat (15) offer({SEL_1X28, 28'hFFFFFFF}, 1'b0);
		need = 32'd0 - sb.running_sum;
		if (sb.decode_mode[1]) begin
			need = need + 32'd1;
		end
		if (need != 32'd0 && need <= 32'h0FFFFFFF) begin
			offer({SEL_1X28, need[27:0]}, 1'b0);
		end
		offer({SEL_1X28, 28'h0}, 1'b0);
	endtask

	initial begin : stimulus
		int          p, k, len, base, raw, kind;
		logic [3:0]  sel;
		logic [23:0] length_v;
		logic [31:0] junk;
		logic        st;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		// Plain mode: every packing at its largest values, the 28x1 packing at its smallest, two bad selectors.
		write_reg(s9wd_pkg::REG_LIST_LENGTH, 24'd1000);
		write_reg(s9wd_pkg::REG_DECODE_MODE, {22'h0, s9wd_pkg::MODE_PLAIN});
		offer({SEL_1X28, 28'hFFFFFFF}, 1'b1);
		for (k = 1; k <= s9wd_pkg::SEL_MAX; k++) begin
			offer({4'(k), 28'hFFFFFFF}, 1'b0);
		end
		offer({SEL_28X1, 28'h0}, 1'b0);
		offer({4'(s9wd_pkg::SEL_MAX + 4'd1), 28'h5A5A5A5}, 1'b0);
		offer({SEL_TOP, 28'hFFFFFFF}, 1'b0);
		settle();

		// Gap mode with a short list: the list runs out inside a word and stays empty.
		write_reg(s9wd_pkg::REG_LIST_LENGTH, 24'd5);
		write_reg(s9wd_pkg::REG_DECODE_MODE, {22'h0, s9wd_pkg::MODE_GAP});
		offer({SEL_28X1, 28'hFFFFFFF}, 1'b1);
		offer({SEL_5X5, 28'h3C3C3C3}, 1'b0);
		offer({SEL_TOP, 28'h0}, 1'b0);
		offer({SEL_1X28, 28'hFFFFFFF}, 1'b1);
		offer({SEL_14X2, 28'hAAAAAAA}, 1'b0);
		settle();

		// Empty list, then boundary mode through the alternate code with the longest list.
		write_reg(s9wd_pkg::REG_LIST_LENGTH, 24'd0);
		write_reg(s9wd_pkg::REG_DECODE_MODE, {22'h2AF35B, MODE_BOUNDARY});
		offer({SEL_5X5, 28'hFFFFFFF}, 1'b1);
		settle();
		write_reg(s9wd_pkg::REG_LIST_LENGTH, 24'hFFFFFF);
		write_reg(s9wd_pkg::REG_DECODE_MODE, {22'h155555, MODE_BOUNDARY_ALT});
		offer({SEL_28X1, 28'h0000005}, 1'b1);
		offer({SEL_5X5, 3'b000, 5'd2, 5'd6, 5'd0, 5'd4, 5'd3}, 1'b1);
		offer({SEL_1X28, 28'h0}, 1'b0);
		offer({SEL_1X28, 28'h0}, 1'b0);
		offer({SEL_14X2, 28'hFFFFFFF}, 1'b0);

		for (p = 0; p < RAND_PHASES; p++) begin
			settle();
			case ($urandom_range(0, 5))
				0: length_v = 24'hFFFFFF;
				1: length_v = 24'($urandom_range(1, 4));
				2: length_v = 24'($urandom_range(5, 40));
				3: length_v = 24'($urandom_range(41, 2000));
				4: length_v = 24'd28;
				default: length_v = 24'($urandom);
			endcase
			if (p == WRAP_PHASE) begin
				length_v = 24'hFFFFFF;
			end
			write_reg(s9wd_pkg::REG_LIST_LENGTH, length_v);
			junk = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
			write_reg(s9wd_pkg::REG_DECODE_MODE, {junk[21:0], 2'(p)});
			if (p == HOLD_PHASE) begin
				hold_req = 1'b1;
			end
			base = items_taken;
			raw = 0;
			while (items_taken - base < PHASE_ITEMS && raw < 3 * PHASE_ITEMS) begin
				sender_calm = ($urandom_range(0, 3) == 0);
				kind = (p == WRAP_PHASE && raw == 0) ? 0 : $urandom_range(0, 11);
				if (kind == 0 && sb.list_length >= 24'd20) begin
					wrap_run();
					raw += 18;
				end else if (kind <= 8) begin
					len = $urandom_range(1, 6);
					for (k = 0; k < len; k++) begin
						if ($urandom_range(0, 11) == 0) begin
							sel = 4'($urandom_range(s9wd_pkg::SEL_MAX + 1, SEL_TOP));
						end else begin
							sel = 4'($urandom_range(0, s9wd_pkg::SEL_MAX));
						end
						st = (k == 0) || ($urandom_range(0, 15) == 0);
						offer(build_word(sel, st, 1'b1), st);
					end
					raw += len;
				end else begin
					st = 1'($urandom_range(0, 1));
					offer($urandom, st);
					raw++;
				end
				if (p == PAUSE_PHASE && raw < 4 || $urandom_range(0, 9) == 0) begin
					settle();
				end
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
